// ----- rtl/core/tcg_pkg.sv -----
`timescale 1ns / 1ps

package tcg_pkg;

    // geometry and store sizes
    localparam int DEF_MAX_GLYPH_WIDTH = 16;
    localparam int DEF_FONT_BYTES      = 16384;
    localparam int MAX_GLYPH_HEIGHT    = 32;
    localparam int PALETTE_ENTRIES     = 16;

    localparam int GW_W    = 5;   // glyph width register
    localparam int GH_W    = 6;   // glyph height register
    localparam int FADDR_W = 14;  // font byte address field
    localparam int COLOR_W = 24;
    localparam int PIX_X_W = 12;
    localparam int PIX_Y_W = 11;

    // command field codes
    typedef enum logic [1:0] {
        CMD_RENDER = 2'd0,
        CMD_FONT   = 2'd1,
        CMD_PAL    = 2'd2
    } cmd_t;

    // configuration register indexes
    typedef enum logic {
        CFG_GLYPH_WIDTH  = 1'b0,
        CFG_GLYPH_HEIGHT = 1'b1
    } cfg_idx_t;

    // what an item does once it reaches the stores
    typedef enum logic [1:0] {
        KIND_RENDER = 2'd0,
        KIND_FONT   = 2'd1,
        KIND_PAL    = 2'd2
    } kind_t;

    // standard ega sixteen colours, palette reset value
    localparam logic [COLOR_W-1:0] EGA_COLORS [PALETTE_ENTRIES] = '{
        24'h000000, 24'hAA0000, 24'h00AA00, 24'hAAAA00,
        24'h0000AA, 24'hAA00AA, 24'h00AAAA, 24'hAAAAAA,
        24'h555555, 24'hFF5555, 24'h55FF55, 24'hFFFF55,
        24'h5555FF, 24'hFF55FF, 24'h55FFFF, 24'hFFFFFF
    };

    // item leaving the address stage towards the stores
    typedef struct packed {
        kind_t                kind;
        logic [GW_W-1:0]      w;
        logic [FADDR_W-1:0]   addr0;
        logic [FADDR_W-1:0]   addr1;
        logic [PIX_X_W-1:0]   x_base;
        logic [PIX_Y_W-1:0]   y;
        logic [3:0]           fg_index;
        logic [3:0]           bg_index;
        logic [7:0]           font_byte;
        logic [3:0]           pal_index;
        logic [COLOR_W-1:0]   pal_color;
    } tcg_op_t;

    // scan line ready for the pixel sequencer
    typedef struct packed {
        logic [GW_W-1:0]      w;
        logic [PIX_X_W-1:0]   x_base;
        logic [PIX_Y_W-1:0]   y;
        logic [15:0]          glyph;
        logic [COLOR_W-1:0]   fg_color;
        logic [COLOR_W-1:0]   bg_color;
    } tcg_pix_t;

endpackage

// ----- rtl/core/tcg_geom.sv -----
`timescale 1ns / 1ps

module tcg_geom
    import tcg_pkg::*;
#(
    parameter int MAX_GLYPH_WIDTH = DEF_MAX_GLYPH_WIDTH,
    parameter int FONT_BYTES      = DEF_FONT_BYTES
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         command,
    input  logic [5:0]         cell_row,
    input  logic [7:0]         cell_col,
    input  logic [4:0]         scan_line,
    input  logic [7:0]         char_code,
    input  logic [3:0]         fg_index,
    input  logic [3:0]         bg_index,
    input  logic [13:0]        font_addr,
    input  logic [7:0]         font_byte,
    input  logic [3:0]         palette_index,
    input  logic [23:0]        palette_color,
    input  logic [GW_W-1:0]    glyph_w,
    input  logic [GH_W-1:0]    glyph_h,
    output logic               op_valid,
    output tcg_op_t            op,
    input  logic               op_ready
);

    localparam logic [GW_W-1:0] W_MAX = GW_W'(MAX_GLYPH_WIDTH);
    localparam logic [GH_W-1:0] H_MAX = GH_W'(MAX_GLYPH_HEIGHT);
    localparam logic [17:0]     FB1   = 18'(FONT_BYTES);
    localparam logic [17:0]     FB2   = 18'(2 * FONT_BYTES);
    localparam logic [17:0]     FB4   = 18'(4 * FONT_BYTES);

    // address below eight times the store size, reduced by restoring steps
    function automatic logic [FADDR_W-1:0] font_wrap(input logic [17:0] v);
        logic [17:0] r;
        r = v;
        if (r >= FB4)
            r = r - FB4;
        if (r >= FB2)
            r = r - FB2;
        if (r >= FB1)
            r = r - FB1;
        return r[FADDR_W-1:0];
    endfunction

    logic [GW_W-1:0]    w_clamp;
    logic [GH_W-1:0]    h_clamp;
    logic               keep;
    kind_t              kind_in;

    // stage one registers
    logic               v1_reg;
    kind_t              kind1_reg;
    logic [GW_W-1:0]    w1_reg;
    logic               wide1_reg;
    logic [13:0]        chh1_reg;
    logic [11:0]        rowh1_reg;
    logic [12:0]        colw1_reg;
    logic [4:0]         line1_reg;
    logic [3:0]         fg1_reg;
    logic [3:0]         bg1_reg;
    logic [13:0]        faddr1_reg;
    logic [7:0]         fbyte1_reg;
    logic [3:0]         pidx1_reg;
    logic [23:0]        pcol1_reg;

    // stage two registers
    logic               v2_reg;
    tcg_op_t            op_reg;
    tcg_op_t            op_next;

    logic               rdy1;
    logic               rdy2;
    logic [13:0]        row_sum;
    logic [13:0]        base;
    logic [11:0]        y_sum;

    always_comb
    begin
        w_clamp = (glyph_w > W_MAX) ? W_MAX : glyph_w;
        h_clamp = (glyph_h > H_MAX) ? H_MAX : glyph_h;
        case (command)
            CMD_RENDER:
            begin
                kind_in = KIND_RENDER;
                keep    = (w_clamp != '0) && (h_clamp != '0) &&
                          ({1'b0, scan_line} < h_clamp);
            end
            CMD_FONT:
            begin
                kind_in = KIND_FONT;
                keep    = (15'(font_addr) < 15'(FONT_BYTES));
            end
            CMD_PAL:
            begin
                kind_in = KIND_PAL;
                keep    = 1'b1;
            end
            default:
            begin
                kind_in = KIND_RENDER;
                keep    = 1'b0;
            end
        endcase
    end

    assign rdy2     = !v2_reg || op_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign in_stall = !rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid && keep;
            if (rdy2)
                v2_reg <= v1_reg;
        end
    end

    // stage one: the three products
    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            kind1_reg  <= kind_in;
            w1_reg     <= w_clamp;
            wide1_reg  <= (w_clamp > GW_W'(8));
            chh1_reg   <= 14'(char_code) * 14'(h_clamp);
            rowh1_reg  <= 12'(cell_row) * 12'(h_clamp);
            colw1_reg  <= 13'(cell_col) * 13'(w_clamp);
            line1_reg  <= scan_line;
            fg1_reg    <= fg_index;
            bg1_reg    <= bg_index;
            faddr1_reg <= font_addr;
            fbyte1_reg <= font_byte;
            pidx1_reg  <= palette_index;
            pcol1_reg  <= palette_color;
        end
    end

    // stage two: glyph row address and screen y
    always_comb
    begin
        row_sum = chh1_reg + 14'(line1_reg);
        base    = wide1_reg ? {row_sum[12:0], 1'b0} : row_sum;
        y_sum   = rowh1_reg + 12'(line1_reg);

        op_next.kind      = kind1_reg;
        op_next.w         = w1_reg;
        op_next.addr0     = (kind1_reg == KIND_FONT) ? faddr1_reg : font_wrap(18'(base));
        op_next.addr1     = font_wrap(18'(base) + 18'd1);
        op_next.x_base    = colw1_reg[PIX_X_W-1:0];
        op_next.y         = y_sum[PIX_Y_W-1:0];
        op_next.fg_index  = fg1_reg;
        op_next.bg_index  = bg1_reg;
        op_next.font_byte = fbyte1_reg;
        op_next.pal_index = pidx1_reg;
        op_next.pal_color = pcol1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rdy2)
            op_reg <= op_next;
    end

    assign op_valid = v2_reg;
    assign op       = op_reg;

endmodule

// ----- rtl/core/tcg_store.sv -----
`timescale 1ns / 1ps

module tcg_store
    import tcg_pkg::*;
#(
    parameter int FONT_BYTES = DEF_FONT_BYTES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        op_valid,
    input  tcg_op_t     op,
    output logic        op_ready,
    output logic        pix_valid,
    output tcg_pix_t    pix,
    input  logic        pix_take
);

    localparam int FAW = $clog2(FONT_BYTES);

    logic [7:0]                  font_mem [FONT_BYTES];
    logic [COLOR_W-1:0]          pal_mem  [PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0]  pal_set_reg;

    logic               pix_valid_reg;
    logic [7:0]         byte0_reg;
    logic [7:0]         byte1_reg;
    logic [COLOR_W-1:0] fg_word_reg;
    logic [COLOR_W-1:0] bg_word_reg;
    logic               fg_ok_reg;
    logic               bg_ok_reg;
    logic [3:0]         fg_idx_reg;
    logic [3:0]         bg_idx_reg;
    logic [GW_W-1:0]    w_reg;
    logic [PIX_X_W-1:0] x_base_reg;
    logic [PIX_Y_W-1:0] y_reg;

    logic               adv;

    assign op_ready = !pix_valid_reg || pix_take;
    assign adv      = op_valid && op_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
            pal_set_reg   <= '0;
        end
        else
        begin
            if (adv)
                pix_valid_reg <= (op.kind == KIND_RENDER);
            else if (pix_take)
                pix_valid_reg <= 1'b0;
            if (adv && (op.kind == KIND_PAL))
                pal_set_reg[op.pal_index] <= 1'b1;
        end
    end

    // writes and registered reads; one item touches the stores per cycle
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (op.kind == KIND_FONT)
                font_mem[op.addr0[FAW-1:0]] <= op.font_byte;
            if (op.kind == KIND_PAL)
                pal_mem[op.pal_index] <= op.pal_color;
            if (op.kind == KIND_RENDER)
            begin
                byte0_reg   <= font_mem[op.addr0[FAW-1:0]];
                byte1_reg   <= font_mem[op.addr1[FAW-1:0]];
                fg_word_reg <= pal_mem[op.fg_index];
                bg_word_reg <= pal_mem[op.bg_index];
                fg_ok_reg   <= pal_set_reg[op.fg_index];
                bg_ok_reg   <= pal_set_reg[op.bg_index];
                fg_idx_reg  <= op.fg_index;
                bg_idx_reg  <= op.bg_index;
                w_reg       <= op.w;
                x_base_reg  <= op.x_base;
                y_reg       <= op.y;
            end
        end
    end

    // an entry never written reads as its ega reset colour
    always_comb
    begin
        pix.w        = w_reg;
        pix.x_base   = x_base_reg;
        pix.y        = y_reg;
        pix.glyph    = {byte0_reg, byte1_reg};
        pix.fg_color = fg_ok_reg ? fg_word_reg : EGA_COLORS[fg_idx_reg];
        pix.bg_color = bg_ok_reg ? bg_word_reg : EGA_COLORS[bg_idx_reg];
    end

    assign pix_valid = pix_valid_reg;

endmodule

// ----- rtl/core/tcg_emit.sv -----
`timescale 1ns / 1ps

module tcg_emit
    import tcg_pkg::*;
#(
    parameter int MAX_GLYPH_WIDTH = DEF_MAX_GLYPH_WIDTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pix_valid,
    input  tcg_pix_t            pix,
    output logic                pix_take,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [PIX_X_W-1:0]  pixel_x,
    output logic [PIX_Y_W-1:0]  pixel_y,
    output logic [COLOR_W-1:0]  pixel_color,
    output logic                last_pixel
);

    localparam int CW = $clog2(MAX_GLYPH_WIDTH);

    logic [CW-1:0]      cnt_reg;
    logic [CW-1:0]      cnt_next;
    logic               out_valid_reg;
    logic [PIX_X_W-1:0] x_reg;
    logic [PIX_Y_W-1:0] y_reg;
    logic [COLOR_W-1:0] color_reg;
    logic               last_reg;

    logic               out_free;
    logic               fire;
    logic               last;
    logic               bit_set;
    logic [3:0]         bit_idx;

    assign out_free = !out_valid_reg || !out_stall;
    assign fire     = pix_valid && out_free;
    assign last     = (GW_W'(cnt_reg) == (pix.w - GW_W'(1)));
    assign pix_take = fire && last;
    assign bit_idx  = 4'd15 - 4'(cnt_reg);
    assign bit_set  = pix.glyph[bit_idx];
    assign cnt_next = last ? '0 : cnt_reg + CW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (out_free)
                out_valid_reg <= pix_valid;
            if (fire)
                cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            x_reg     <= pix.x_base + PIX_X_W'(cnt_reg);
            y_reg     <= pix.y;
            color_reg <= bit_set ? pix.fg_color : pix.bg_color;
            last_reg  <= last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = x_reg;
    assign pixel_y     = y_reg;
    assign pixel_color = color_reg;
    assign last_pixel  = last_reg;

endmodule

// ----- rtl/core/text_cell_glyph_renderer_unit.sv -----
`timescale 1ns / 1ps
// after its item is accepted, the first pixel of a scan line passes the address-stage registers,
// the store read registers and the output register; throughput: one pixel per cycle while
// out_stall is low; a render item holds the pixel stage until all its pixels are out, font and
// palette writes carry no pixel and leave the output idle when they sit between two scan lines;
// dropped items cost nothing past the input; reset: async active low; clears valid bits, glyph
// geometry to 8x16, palette to ega colours; the font store has no reset and holds whatever is written to it

module text_cell_glyph_renderer_unit
    import tcg_pkg::*;
#(
    parameter int MAX_GLYPH_WIDTH = DEF_MAX_GLYPH_WIDTH,
    parameter int FONT_BYTES      = DEF_FONT_BYTES
)
(
    input  logic                clk,
    input  logic                rst_n,

    // configuration write port
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [GH_W-1:0]     cfg_data,

    // item in
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          command,
    input  logic [5:0]          cell_row,
    input  logic [7:0]          cell_col,
    input  logic [4:0]          scan_line,
    input  logic [7:0]          char_code,
    input  logic [3:0]          fg_index,
    input  logic [3:0]          bg_index,
    input  logic [13:0]         font_addr,
    input  logic [7:0]          font_byte,
    input  logic [3:0]          palette_index,
    input  logic [23:0]         palette_color,

    // pixel out
    output logic                out_valid,
    input  logic                out_stall,
    output logic [PIX_X_W-1:0]  pixel_x,
    output logic [PIX_Y_W-1:0]  pixel_y,
    output logic [COLOR_W-1:0]  pixel_color,
    output logic                last_pixel
);

    // glyph geometry; the user must write it only while the pipe is empty, the block does not enforce it
    logic [GW_W-1:0] glyph_w_reg;
    logic [GH_W-1:0] glyph_h_reg;

    // address stage to store stage
    logic            op_valid;
    logic            op_ready;
    tcg_op_t         op;

    // store stage to pixel sequencer
    logic            pix_valid;
    logic            pix_take;
    tcg_pix_t        pix;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glyph_w_reg <= GW_W'(8);
            glyph_h_reg <= GH_W'(16);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GLYPH_WIDTH:  glyph_w_reg <= cfg_data[GW_W-1:0];
                CFG_GLYPH_HEIGHT: glyph_h_reg <= cfg_data;
                default:          glyph_w_reg <= glyph_w_reg;
            endcase
        end
    end

    // stages one and two: geometry clamp, products, glyph row address, screen y
    tcg_geom #(
        .MAX_GLYPH_WIDTH (MAX_GLYPH_WIDTH),
        .FONT_BYTES      (FONT_BYTES)
    ) u_geom (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .cell_row      (cell_row),
        .cell_col      (cell_col),
        .scan_line     (scan_line),
        .char_code     (char_code),
        .fg_index      (fg_index),
        .bg_index      (bg_index),
        .font_addr     (font_addr),
        .font_byte     (font_byte),
        .palette_index (palette_index),
        .palette_color (palette_color),
        .glyph_w       (glyph_w_reg),
        .glyph_h       (glyph_h_reg),
        .op_valid      (op_valid),
        .op            (op),
        .op_ready      (op_ready)
    );

    // stage three: font and palette stores, writes in item order, registered reads
    tcg_store #(
        .FONT_BYTES (FONT_BYTES)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op        (op),
        .op_ready  (op_ready),
        .pix_valid (pix_valid),
        .pix       (pix),
        .pix_take  (pix_take)
    );

    // pixel sequencer: one pixel a cycle into the output register while out_stall does not hold it
    tcg_emit #(
        .MAX_GLYPH_WIDTH (MAX_GLYPH_WIDTH)
    ) u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .pix_valid   (pix_valid),
        .pix         (pix),
        .pix_take    (pix_take),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_color (pixel_color),
        .last_pixel  (last_pixel)
    );

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import tcg_pkg::*;

    // the package has no name for the spare command code
    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         NUM_PHASES   = 11;
    localparam int         LONG_HOLD    = 250;   // receiver hold-off, in cycles
    localparam int         SETTLE       = 12;    // pipeline depth plus margin
    localparam int         TIMEOUT_NS   = 12_000_000;

    // one input item, every field of the input side
    typedef struct {
        logic [1:0]  command;
        logic [5:0]  cell_row;
        logic [7:0]  cell_col;
        logic [4:0]  scan_line;
        logic [7:0]  char_code;
        logic [3:0]  fg_index;
        logic [3:0]  bg_index;
        logic [13:0] font_addr;
        logic [7:0]  font_byte;
        logic [3:0]  palette_index;
        logic [23:0] palette_color;
    } cell_item_t;

    // one rendered pixel
    typedef struct {
        logic [PIX_X_W-1:0] x;
        logic [PIX_Y_W-1:0] y;
        logic [COLOR_W-1:0] color;
        logic               last;
    } pixel_t;

    // shadow of the font store, palette and geometry, plus the pixels still owed
    class glyph_scoreboard;
        logic [7:0]         font_store [DEF_FONT_BYTES];
        bit                 font_written [DEF_FONT_BYTES];
        logic [COLOR_W-1:0] palette [PALETTE_ENTRIES];
        logic [GW_W-1:0]    width_reg;
        logic [GH_W-1:0]    height_reg;
        pixel_t             pixel_q [$];
        int                 errors;

        function new();
            foreach (palette[i])
                palette[i] = EGA_COLORS[i];
            width_reg  = 5'd8;
            height_reg = 6'd16;
            errors     = 0;
        endfunction

        // geometry as the block uses it, clamped to the maxima
        function int unsigned eff_w();
            return (width_reg > DEF_MAX_GLYPH_WIDTH) ? DEF_MAX_GLYPH_WIDTH : width_reg;
        endfunction

        function int unsigned eff_h();
            return (height_reg > MAX_GLYPH_HEIGHT) ? MAX_GLYPH_HEIGHT : height_reg;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [GH_W-1:0] val);
            if (idx == CFG_GLYPH_WIDTH)
                width_reg = val[GW_W-1:0];
            else
                height_reg = val;
        endfunction

        // expected pixels of one scan line, left to right
        function void predict_scan_line(cell_item_t it);
            int unsigned w, h, bpl, base, b;
            logic [7:0]  bits;
            pixel_t      px;
            w = eff_w();
            h = eff_h();
            if (w == 0 || h == 0 || it.scan_line >= h)
                return;
            bpl  = (w - 1) / 8 + 1;
            base = it.char_code * h * bpl + it.scan_line * bpl;
            for (b = 0; b < w; b++)
            begin
                bits     = font_store[(base + b / 8) % DEF_FONT_BYTES];
                px.x     = PIX_X_W'(it.cell_col * w + b);
                px.y     = PIX_Y_W'(it.cell_row * h + it.scan_line);
                px.color = bits[7 - (b % 8)] ? palette[it.fg_index] : palette[it.bg_index];
                px.last  = (b == w - 1);
                pixel_q.push_back(px);
            end
        endfunction

        function void note_item(cell_item_t it);
            case (it.command)
                CMD_RENDER: predict_scan_line(it);
                CMD_FONT:
                begin
                    font_store[it.font_addr]   = it.font_byte;
                    font_written[it.font_addr] = 1'b1;
                end
                CMD_PAL:    palette[it.palette_index] = it.palette_color;
                default:    ;
            endcase
        endfunction

        function void check_pixel(pixel_t got);
            pixel_t want;
            if (pixel_q.size() == 0)
            begin
                $error("pixel with none expected: x %0d y %0d", got.x, got.y);
                errors++;
            end
            else
            begin
                want = pixel_q.pop_front();
                if (got.x !== want.x)
                begin
                    $error("pixel_x expected %0d actual %0d", want.x, got.x);
                    errors++;
                end
                if (got.y !== want.y)
                begin
                    $error("pixel_y expected %0d actual %0d", want.y, got.y);
                    errors++;
                end
                if (got.color !== want.color)
                begin
                    $error("pixel_color expected %06h actual %06h", want.color, got.color);
                    errors++;
                end
                if (got.last !== want.last)
                begin
                    $error("last_pixel expected %0b actual %0b", want.last, got.last);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return pixel_q.size();
        endfunction
    endclass

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // configuration port
    logic            cfg_we    = 1'b0;
    logic            cfg_index = CFG_GLYPH_WIDTH;
    logic [GH_W-1:0] cfg_data  = '0;

    // input channel
    logic        in_valid      = 1'b0;
    logic        in_stall;
    logic [1:0]  command       = CMD_RENDER;
    logic [5:0]  cell_row      = '0;
    logic [7:0]  cell_col      = '0;
    logic [4:0]  scan_line     = '0;
    logic [7:0]  char_code     = '0;
    logic [3:0]  fg_index      = '0;
    logic [3:0]  bg_index      = '0;
    logic [13:0] font_addr     = '0;
    logic [7:0]  font_byte     = '0;
    logic [3:0]  palette_index = '0;
    logic [23:0] palette_color = '0;

    // output channel
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [PIX_X_W-1:0] pixel_x;
    logic [PIX_Y_W-1:0] pixel_y;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_pixel;

    // traffic shaping flags for the sender and the receiver
    bit tx_gaps  = 1'b1;
    bit rx_gaps  = 1'b1;
    bit hold_req = 1'b0;

    glyph_scoreboard board = new();

    text_cell_glyph_renderer_unit dut (.*);

    always #10 clk = ~clk;

    // hard stop in case the block hangs
    initial
    begin
        #(TIMEOUT_NS);
        $display("simulation failed");
        $finish;
    end

    // every field random, the caller overrides what matters for the command
    function automatic cell_item_t random_item();
        cell_item_t it;
        it.command       = 2'($urandom);
        it.cell_row      = 6'($urandom);
        it.cell_col      = 8'($urandom);
        it.scan_line     = 5'($urandom);
        it.char_code     = 8'($urandom);
        it.fg_index      = 4'($urandom);
        it.bg_index      = 4'($urandom);
        it.font_addr     = 14'($urandom);
        it.font_byte     = 8'($urandom);
        it.palette_index = 4'($urandom);
        it.palette_color = 24'($urandom);
        return it;
    endfunction

    // offer one item, hold it until taken, then maybe leave a gap
    task automatic send_item(input cell_item_t it);
        command       <= it.command;
        cell_row      <= it.cell_row;
        cell_col      <= it.cell_col;
        scan_line     <= it.scan_line;
        char_code     <= it.char_code;
        fg_index      <= it.fg_index;
        bg_index      <= it.bg_index;
        font_addr     <= it.font_addr;
        font_byte     <= it.font_byte;
        palette_index <= it.palette_index;
        palette_color <= it.palette_color;
        in_valid      <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_item(it);
        if (tx_gaps && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    task automatic send_font(input logic [13:0] addr, input logic [7:0] data);
        cell_item_t it;
        it           = random_item();
        it.command   = CMD_FONT;
        it.font_addr = addr;
        it.font_byte = data;
        send_item(it);
    endtask

    task automatic send_palette(input logic [3:0] idx, input logic [23:0] colour);
        cell_item_t it;
        it               = random_item();
        it.command       = CMD_PAL;
        it.palette_index = idx;
        it.palette_color = colour;
        send_item(it);
    endtask

    // render one scan line; glyph bytes never written yet get random content first
    task automatic send_render(input logic [5:0] row, input logic [7:0] col,
                               input logic [4:0] line, input logic [7:0] ch,
                               input logic [3:0] fg, input logic [3:0] bg);
        cell_item_t  it;
        int unsigned w, h, bpl, a, k;
        w = board.eff_w();
        h = board.eff_h();
        if (w != 0 && h != 0 && line < h)
        begin
            bpl = (w - 1) / 8 + 1;
            for (k = 0; k < bpl; k++)
            begin
                a = (ch * h * bpl + line * bpl + k) % DEF_FONT_BYTES;
                if (!board.font_written[a])
                    send_font(14'(a), 8'($urandom_range(0, 255)));
            end
        end
        it           = random_item();
        it.command   = CMD_RENDER;
        it.cell_row  = row;
        it.cell_col  = col;
        it.scan_line = line;
        it.char_code = ch;
        it.fg_index  = fg;
        it.bg_index  = bg;
        send_item(it);
    endtask

    // mostly renders within the glyph, some beyond it, writes and the spare code
    task automatic random_items(input int n);
        cell_item_t  it;
        int unsigned h, line;
        repeat (n)
        begin
            h  = board.eff_h();
            it = random_item();
            case ($urandom_range(0, 9))
                7:
                    send_font(14'($urandom_range(0, DEF_FONT_BYTES - 1)),
                              8'($urandom_range(0, 255)));
                8:
                    send_palette(it.palette_index, it.palette_color);
                9:
                begin
                    it.command = CMD_UNUSED;
                    send_item(it);
                end
                default:
                begin
                    if (h != 0 && $urandom_range(0, 4) != 0)
                        line = $urandom_range(0, h - 1);
                    else
                        line = $urandom_range(0, 31);
                    // a handful of codes so glyphs get reused
                    if ($urandom_range(0, 1) == 1)
                        it.char_code = 8'($urandom_range(0, 7));
                    send_render(it.cell_row, it.cell_col, 5'(line), it.char_code,
                                it.fg_index, it.bg_index);
                end
            endcase
        end
    endtask

    // stop offering and wait until every pixel is out and the pipe is empty
    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // both geometry registers, back to back
    task automatic write_geometry(input logic [GH_W-1:0] w, input logic [GH_W-1:0] h);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_GLYPH_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        board.set_reg(CFG_GLYPH_WIDTH, w);
        cfg_index <= CFG_GLYPH_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        board.set_reg(CFG_GLYPH_HEIGHT, h);
        cfg_we    <= 1'b0;
    endtask

    // result monitor
    always @(posedge clk)
    begin
        pixel_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.x     = pixel_x;
            got.y     = pixel_y;
            got.color = pixel_color;
            got.last  = last_pixel;
            board.check_pixel(got);
        end
    end

    // receiver: random stall bursts, quiet stretches, and one long hold-off on request
    initial
    begin
        int unsigned held;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                held = 0;
                while (held < LONG_HOLD)
                begin
                    @(posedge clk);
                    held++;
                end
                out_stall <= 1'b0;
                hold_req = 1'b0;
            end
            else if (rx_gaps && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
            begin
                repeat ($urandom_range(0, 12)) @(posedge clk);
            end
        end
    end

    // main sequence
    initial
    begin
        int unsigned phase_w [8];
        int unsigned phase_h [8];
        int unsigned w, h;
        int          p;
        cell_item_t  it;

        // geometry per phase: defaults, smallest, largest, zero width, zero height,
        // oversized, two bytes per row, all register bits set
        phase_w = '{8, 1, 16, 0, 8, 20, 9, 31};
        phase_h = '{16, 1, 32, 16, 0, 40, 8, 63};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, reset geometry 8x16
        send_font(14'd0, 8'hFF);                              // char 0 line 0 solid
        send_render(6'd0, 8'd0, 5'd0, 8'd0, 4'd15, 4'd0);
        send_font(14'd16, 8'h00);                             // char 1 line 0 blank
        send_render(6'd0, 8'd0, 5'd0, 8'd1, 4'd15, 4'd0);
        send_font(14'd17, 8'h81);                             // edge bits only
        send_render(6'd63, 8'd255, 5'd1, 8'd1, 4'd9, 4'd4);   // far corner of the screen
        send_render(6'd5, 8'd7, 5'd16, 8'd0, 4'd1, 4'd2);     // first line past the glyph
        send_render(6'd5, 8'd7, 5'd31, 8'd0, 4'd1, 4'd2);     // last line past the glyph
        send_palette(4'd0, 24'hFFFFFF);
        send_palette(4'd15, 24'h000000);
        send_render(6'd1, 8'd2, 5'd0, 8'd0, 4'd15, 4'd0);     // swapped colours
        send_render(6'd1, 8'd3, 5'd1, 8'd1, 4'd0, 4'd15);
        send_palette(4'd7, 24'h5AA5C3);
        send_render(6'd2, 8'd4, 5'd1, 8'd1, 4'd7, 4'd7);      // same index both sides
        send_font(14'd16383, 8'hA5);                          // top of the font store
        send_font(14'h2AAA, 8'h5A);
        it         = random_item();
        it.command = CMD_UNUSED;                              // spare code, no effect
        send_item(it);
        it         = '{CMD_UNUSED, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1};
        send_item(it);
        send_render(6'd0, 8'd1, 5'd0, 8'd0, 4'd0, 4'd15);

        for (p = 0; p < NUM_PHASES; p++)
        begin
            // registers change only with the block empty
            drain();
            if (p < 8)
            begin
                w = phase_w[p];
                h = phase_h[p];
            end
            else
            begin
                w = $urandom_range(1, DEF_MAX_GLYPH_WIDTH);
                h = $urandom_range(1, MAX_GLYPH_HEIGHT);
            end
            // last phase runs with no idling on either side
            if (p == NUM_PHASES - 1)
            begin
                tx_gaps = 1'b0;
                rx_gaps = 1'b0;
            end
            write_geometry(GH_W'(w), GH_W'(h));

            if (p == 2)
            begin
                // receiver holds off while wide lines keep coming, so the block backs up
                hold_req = 1'b1;
                tx_gaps  = 1'b0;
                send_render(6'd63, 8'd255, 5'd31, 8'd255, 4'd15, 4'd0);
                repeat (16)
                begin
                    it = random_item();
                    send_render(it.cell_row, it.cell_col, it.scan_line, it.char_code,
                                it.fg_index, it.bg_index);
                end
                tx_gaps = 1'b1;
            end
            random_items(10);
        end

        drain();
        if (board.errors == 0 && board.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
